[src/bks_pkg.sv]
// ----------------------------------------------------------------------------
// bks_pkg
// Shared types and map constants for the byte key schedule step block.
// ----------------------------------------------------------------------------
`default_nettype none

package bks_pkg;

    // Four schedule bytes; index 0 is the first byte of the key.
    typedef logic [3:0][7:0] sched_t;

    // Mixing algorithm number
    typedef logic [2:0] alg_sel_t;

    // Input beat
    typedef struct packed {
        logic        action;
        logic [31:0] key_word;
        logic [7:0]  map_number;
    } item_t;

    // Result beat
    typedef struct packed {
        logic [7:0]  rng_first;
        logic [7:0]  rng_second;
        logic [15:0] nibble_select;
        logic        last_entry;
    } result_t;

    // Action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_MAP  = 1'b1;

    // Maps with special handling
    localparam logic [7:0] MAP_PREMIX = 8'h1B;
    localparam logic [7:0] MAP_FIXED  = 8'h06;
    localparam logic [7:0] MAP_DOUBLE = 8'h22;

    // Mixing algorithm numbers
    localparam alg_sel_t ALG_ZERO   = 3'd0;
    localparam alg_sel_t ALG_ONE    = 3'd1;
    localparam alg_sel_t ALG_TWO    = 3'd2;
    localparam alg_sel_t ALG_THREE  = 3'd3;
    localparam alg_sel_t ALG_FOUR   = 3'd4;
    localparam alg_sel_t ALG_FIVE   = 3'd5;
    localparam alg_sel_t ALG_SIX    = 3'd6;

    // Algorithms used by the special maps
    localparam alg_sel_t ALG_PREMIX = 3'd6;
    localparam alg_sel_t ALG_EXTRA  = 3'd4;

endpackage

`default_nettype wire

[src/bks_mix.sv]
// ----------------------------------------------------------------------------
// bks_mix
// One pass of a chosen mixing algorithm over the four schedule bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module bks_mix (
    input  wire bks_pkg::sched_t   state_in,
    input  wire logic [7:0]        map_number,
    input  wire bks_pkg::alg_sel_t alg,
    output bks_pkg::sched_t        state_out
);
    import bks_pkg::*;

    // Add the bytes from the last down to the first, carrying between them
    function automatic sched_t carry_chain(input sched_t s, input logic [7:0] seed,
                                           input logic carry_in);
        sched_t     r;
        logic [8:0] t;
        logic [7:0] sum;
        logic       c;
        r   = s;
        sum = seed;
        c   = carry_in;
        for (int i = 3; i >= 0; i--)
        begin
            t    = {1'b0, sum} + {1'b0, r[i]} + {8'd0, c};
            sum  = t[7:0];
            r[i] = sum;
            c    = t[8];
        end
        return r;
    endfunction

    function automatic sched_t alg_zero(input sched_t s, input logic [7:0] m);
        logic [8:0] t;
        logic [8:0] sub;
        logic [8:0] diff;
        logic       no_borrow;
        t         = {1'b0, m ^ s[1]} + {1'b0, s[0]};
        sub       = {1'b0, s[2]} + {8'd0, ~t[8]};
        no_borrow = ({1'b0, t[7:0]} >= sub);
        diff      = {1'b0, t[7:0]} - sub;
        return carry_chain(s, diff[7:0], no_borrow);
    endfunction

    function automatic sched_t alg_one(input sched_t s, input logic [7:0] m);
        return carry_chain(s, m, 1'b1);
    endfunction

    function automatic sched_t alg_two(input sched_t s, input logic [7:0] m);
        sched_t r;
        r[0] = s[3];
        r[1] = s[2];
        r[2] = s[1];
        r[3] = s[0] + m;
        return r;
    endfunction

    function automatic sched_t alg_five(input sched_t s, input logic [7:0] m);
        sched_t r;
        r[0] = ~{m[6:0], 1'b0} + s[0] - m;
        r[1] = s[3];
        r[2] = s[1];
        r[3] = s[2];
        return r;
    endfunction

    // Select the algorithm; algorithms three, four, six and seven chain two primitives
    always_comb
    begin
        case (alg)
            ALG_ZERO:  state_out = alg_zero(state_in, map_number);
            ALG_ONE:   state_out = alg_one(state_in, map_number);
            ALG_TWO:   state_out = alg_two(state_in, map_number);
            ALG_THREE: state_out = alg_one(alg_two(state_in, map_number), map_number);
            ALG_FOUR:  state_out = alg_zero(alg_two(state_in, map_number), map_number);
            ALG_FIVE:  state_out = alg_five(state_in, map_number);
            ALG_SIX:   state_out = alg_one(alg_five(state_in, map_number), map_number);
            default:   state_out = alg_zero(alg_five(state_in, map_number), map_number);
        endcase
    end

endmodule

`default_nettype wire

[src/byte_key_schedule_step.sv]
// ----------------------------------------------------------------------------
// byte_key_schedule_step
// Four-byte key schedule: key loads and map-driven mixing steps.
// ----------------------------------------------------------------------------
// A load beat gives no result. A map beat gives one result, except map 0x1B,
// which runs a silent premix pass first, and map 0x22, which runs a main and
// an extra pass and gives two results. The mixing unit runs one algorithm pass
// per cycle on the schedule register, except while a result pass waits for a
// free result slot. A new beat is taken in the cycle the current one finishes,
// so ordinary maps stream at one beat per cycle while the result register is
// drained.
`default_nettype none

module byte_key_schedule_step (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire bks_pkg::item_t   item_data,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output bks_pkg::result_t      result_data
);
    import bks_pkg::*;

    typedef enum logic [1:0] {
        PH_LOAD,
        PH_PRE,
        PH_MAIN,
        PH_EXTRA
    } phase_t;

    sched_t   sched_reg, sched_next;
    item_t    cur_reg;
    logic     cur_valid_reg;
    phase_t   phase_reg, phase_next;
    result_t  result_reg, result_next;
    logic     result_valid_reg;

    sched_t   mixed;
    alg_sel_t alg;
    logic     emits;
    logic     slot_free;
    logic     advance;
    logic     finish;
    logic     take;

    // Pick the algorithm for the current phase
    always_comb
    begin
        unique case (phase_reg)
            PH_PRE:   alg = ALG_PREMIX;
            PH_EXTRA: alg = ALG_EXTRA;
            default:
            begin
                if (cur_reg.map_number == MAP_FIXED)
                    alg = ALG_ZERO;
                else
                    alg = sched_reg[cur_reg.map_number[5:4]][4:2];
            end
        endcase
    end

    bks_mix u_mix (
        .state_in   (sched_reg),
        .map_number (cur_reg.map_number),
        .alg        (alg),
        .state_out  (mixed)
    );

    // Handshake and sequencing
    always_comb
    begin
        emits     = (phase_reg == PH_MAIN) || (phase_reg == PH_EXTRA);
        slot_free = !result_valid_reg || result_ready;
        advance   = cur_valid_reg && (!emits || slot_free);
        finish    = advance && ((phase_reg == PH_LOAD) || (phase_reg == PH_EXTRA) ||
                    ((phase_reg == PH_MAIN) && (cur_reg.map_number != MAP_DOUBLE)));
        item_ready = !cur_valid_reg || finish;
        take       = item_valid && item_ready;
    end

    // Next schedule, phase and result
    always_comb
    begin
        sched_next  = sched_reg;
        phase_next  = phase_reg;
        result_next = result_reg;
        if (advance)
        begin
            if (phase_reg == PH_LOAD)
            begin
                sched_next[0] = cur_reg.key_word[31:24];
                sched_next[1] = cur_reg.key_word[23:16];
                sched_next[2] = cur_reg.key_word[15:8];
                sched_next[3] = cur_reg.key_word[7:0];
            end
            else
            begin
                sched_next = mixed;
            end
            if (phase_reg == PH_PRE)
                phase_next = PH_MAIN;
            else if (phase_reg == PH_MAIN)
                phase_next = PH_EXTRA;
            if (emits)
            begin
                result_next.rng_first     = mixed[0];
                result_next.rng_second    = mixed[1];
                result_next.nibble_select = {mixed[3], mixed[2]};
                result_next.last_entry    = finish;
            end
        end
        if (take)
        begin
            if (item_data.action == ACT_LOAD)
                phase_next = PH_LOAD;
            else if (item_data.map_number == MAP_PREMIX)
                phase_next = PH_PRE;
            else
                phase_next = PH_MAIN;
        end
    end

    // Hold state, current beat and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_reg        <= '0;
            cur_reg          <= '0;
            cur_valid_reg    <= 1'b0;
            phase_reg        <= PH_LOAD;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sched_reg  <= sched_next;
            phase_reg  <= phase_next;
            result_reg <= result_next;
            if (take)
                cur_reg <= item_data;
            if (take)
                cur_valid_reg <= 1'b1;
            else if (finish)
                cur_valid_reg <= 1'b0;
            if (advance && emits)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte key schedule step block. A short table of
// directed beats (reset state, key extremes, every mixing algorithm and the
// special maps) is followed by random loads and maps. Both handshakes idle
// at random, and one long receiver hold-off backs the block up. Every result
// beat is checked field by field against a schedule predictor kept here.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bks_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 300;

    // Mixing algorithms by number
    typedef enum logic [2:0] {
        MIX_ADD_SUB,
        MIX_CHAIN,
        MIX_SWAP,
        MIX_SWAP_CHAIN,
        MIX_SWAP_ADD_SUB,
        MIX_ROTATE,
        MIX_ROTATE_CHAIN,
        MIX_ROTATE_ADD_SUB
    } mix_e;

    // One row of directed stimulus, with an optional hand-written result
    typedef struct packed {
        item_t   beat;
        logic    has_want;
        result_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 26;

    dir_row_t directed_rows [DIR_ROWS] = '{
        '{'{ACT_MAP,  32'h0000_0000, MAP_FIXED},  1'b1, '{8'h06, 8'h06, 16'h0606, 1'b1}},
        '{'{ACT_LOAD, 32'h0000_0000, 8'hFF},      1'b0, '0},
        '{'{ACT_MAP,  32'hFFFF_FFFF, 8'h00},      1'b1, '{8'hFF, 8'hFF, 16'hFFFF, 1'b1}},
        '{'{ACT_LOAD, 32'h0400_0000, 8'h00},      1'b0, '0},
        '{'{ACT_MAP,  32'h0000_0000, 8'h00},      1'b1, '{8'h05, 8'h01, 16'h0101, 1'b1}},
        '{'{ACT_LOAD, 32'h835A_C396, 8'h00},      1'b0, '0},
        '{'{ACT_MAP,  32'h0000_0000, 8'h01},      1'b0, '0},
        '{'{ACT_LOAD, 32'h5A87_C396, 8'h00},      1'b0, '0},
        '{'{ACT_MAP,  32'h0000_0000, 8'h11},      1'b0, '0},
        '{'{ACT_LOAD, 32'h5AC3_8B96, 8'h00},      1'b0, '0},
        '{'{ACT_MAP,  32'h0000_0000, 8'h21},      1'b0, '0},
        '{'{ACT_LOAD, 32'h5AC3_968F, 8'h00},      1'b0, '0},
        '{'{ACT_MAP,  32'h0000_0000, 8'h31},      1'b0, '0},
        '{'{ACT_LOAD, 32'h93A5_5A3C, 8'h00},      1'b0, '0},
        '{'{ACT_MAP,  32'h0000_0000, 8'hC1},      1'b0, '0},
        '{'{ACT_LOAD, 32'hA597_3C5A, 8'h00},      1'b0, '0},
        '{'{ACT_MAP,  32'h0000_0000, 8'hD5},      1'b0, '0},
        '{'{ACT_LOAD, 32'h3C5A_9BA5, 8'h00},      1'b0, '0},
        '{'{ACT_MAP,  32'h0000_0000, 8'hE9},      1'b0, '0},
        '{'{ACT_LOAD, 32'h5AA5_3C9F, 8'h00},      1'b0, '0},
        '{'{ACT_MAP,  32'h0000_0000, 8'hFD},      1'b0, '0},
        '{'{ACT_LOAD, 32'hFFFF_FFFF, 8'h00},      1'b0, '0},
        '{'{ACT_MAP,  32'h0000_0000, 8'hFF},      1'b0, '0},
        '{'{ACT_MAP,  32'hFFFF_FFFF, MAP_PREMIX}, 1'b0, '0},
        '{'{ACT_MAP,  32'h0000_0000, MAP_DOUBLE}, 1'b0, '0},
        '{'{ACT_LOAD, 32'h0000_0000, MAP_DOUBLE}, 1'b0, '0}
    };

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item_data;
    logic    result_valid;
    logic    result_ready;
    result_t result_data;

    // Predictor state and the results still owed by the block
    logic [7:0] key_sched [4];
    result_t    pending_results [$];
    result_t    want_beat;

    // Flow control flags
    logic hold_off;
    logic no_idle;
    int   stall_left;
    int   cycle_count;

    // Run statistics
    int accepted_items;
    int load_beats;
    int map_beats;
    int double_maps;
    int premix_maps;
    int fixed_maps;
    int results_seen;
    int mismatch_count;

    byte_key_schedule_step u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Schedule predictor
    // ------------------------------------------------------------------------

    // Add down the bytes from 3 to 0, carrying between them
    function automatic void chain_add(logic [7:0] seed, logic carry_in);
        logic [8:0] t;
        logic [7:0] sum;
        logic       c;
        int         i;
        sum = seed;
        c   = carry_in;
        for (i = 3; i >= 0; i--)
        begin
            t            = {1'b0, sum} + {1'b0, key_sched[i]} + {8'd0, c};
            sum          = t[7:0];
            key_sched[i] = sum;
            c            = t[8];
        end
    endfunction

    // Add, subtract with borrow, then chain the difference through
    function automatic void mix_add_sub(logic [7:0] map);
        logic [8:0] sum9;
        logic [8:0] sub9;
        logic [8:0] diff9;
        sum9  = {1'b0, map ^ key_sched[1]} + {1'b0, key_sched[0]};
        sub9  = {1'b0, key_sched[2]} + {8'd0, ~sum9[8]};
        diff9 = {1'b0, sum9[7:0]} - sub9;
        chain_add(diff9[7:0], {1'b0, sum9[7:0]} >= sub9);
    endfunction

    function automatic void mix_swap(logic [7:0] map);
        logic [7:0] b0;
        logic [7:0] b1;
        b0           = key_sched[0] + map;
        b1           = key_sched[1];
        key_sched[0] = key_sched[3];
        key_sched[1] = key_sched[2];
        key_sched[2] = b1;
        key_sched[3] = b0;
    endfunction

    function automatic void mix_rotate(logic [7:0] map);
        logic [7:0] t;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        t            = {map[6:0], 1'b0} ^ 8'hFF;
        t            = t + key_sched[0] - map;
        b1           = key_sched[1];
        b2           = key_sched[2];
        b3           = key_sched[3];
        key_sched[0] = t;
        key_sched[1] = b3;
        key_sched[2] = b1;
        key_sched[3] = b2;
    endfunction

    function automatic void run_mix(logic [7:0] map, alg_sel_t which);
        case (mix_e'(which))
            MIX_ADD_SUB:        mix_add_sub(map);
            MIX_CHAIN:          chain_add(map, 1'b1);
            MIX_SWAP:           mix_swap(map);
            MIX_SWAP_CHAIN:     begin mix_swap(map); chain_add(map, 1'b1); end
            MIX_SWAP_ADD_SUB:   begin mix_swap(map); mix_add_sub(map); end
            MIX_ROTATE:         mix_rotate(map);
            MIX_ROTATE_CHAIN:   begin mix_rotate(map); chain_add(map, 1'b1); end
            default:            begin mix_rotate(map); mix_add_sub(map); end
        endcase
    endfunction

    function automatic void queue_entry(logic last);
        result_t r;
        r.rng_first     = key_sched[0];
        r.rng_second    = key_sched[1];
        r.nibble_select = {key_sched[3], key_sched[2]};
        r.last_entry    = last;
        pending_results = {pending_results, r};
    endfunction

    // Advance the schedule by one beat and queue the results it owes
    function automatic int advance_schedule(item_t beat);
        alg_sel_t   which;
        logic [7:0] map;
        map = beat.map_number;
        if (beat.action == ACT_LOAD)
        begin
            key_sched[0] = beat.key_word[31:24];
            key_sched[1] = beat.key_word[23:16];
            key_sched[2] = beat.key_word[15:8];
            key_sched[3] = beat.key_word[7:0];
            return 0;
        end
        if (map == MAP_PREMIX)
            run_mix(map, ALG_PREMIX);
        if (map == MAP_FIXED)
            which = ALG_ZERO;
        else
            which = key_sched[map[5:4]][4:2];
        run_mix(map, which);
        if (map == MAP_DOUBLE)
        begin
            queue_entry(1'b0);
            run_mix(map, ALG_EXTRA);
            queue_entry(1'b1);
            return 2;
        end
        queue_entry(1'b1);
        return 1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Drop valid for a random gap, mostly short, now and then long
    task automatic pause_sender();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 65)
            gap = 0;
        else if (pick < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Offer one beat, hold it until taken, then predict what it gives
    task automatic send_beat(item_t beat, logic has_want, result_t want);
        int n;
        item_valid <= 1'b1;
        item_data  <= beat;
        do @(posedge clk); while (!item_ready);
        n = advance_schedule(beat);
        if (has_want && n > 0)
            pending_results[pending_results.size() - 1] = want;
        accepted_items++;
        if (beat.action == ACT_LOAD)
            load_beats++;
        else
        begin
            map_beats++;
            if (beat.map_number == MAP_DOUBLE)
                double_maps++;
            if (beat.map_number == MAP_PREMIX)
                premix_maps++;
            if (beat.map_number == MAP_FIXED)
                fixed_maps++;
        end
        pause_sender();
    endtask

    // Mostly maps, with the special maps and key loads mixed in
    function automatic item_t random_item();
        item_t       beat;
        int unsigned pick;
        pick            = $urandom_range(0, 99);
        beat.key_word   = $urandom;
        beat.map_number = 8'($urandom_range(0, 255));
        beat.action     = ACT_MAP;
        if (pick < 15)
            beat.action = ACT_LOAD;
        else if (pick < 22)
            beat.map_number = MAP_DOUBLE;
        else if (pick < 29)
            beat.map_number = MAP_PREMIX;
        else if (pick < 34)
            beat.map_number = MAP_FIXED;
        return beat;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
                 $realtime, what, got, want, results_seen);
        mismatch_count++;
    endtask

    // Check each accepted result beat, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", result_data[32:1], '0);
            else
            begin
                want_beat = pending_results.pop_front();
                if (result_data.rng_first !== want_beat.rng_first)
                    report_mismatch("rng_first", 32'(result_data.rng_first),
                                    32'(want_beat.rng_first));
                if (result_data.rng_second !== want_beat.rng_second)
                    report_mismatch("rng_second", 32'(result_data.rng_second),
                                    32'(want_beat.rng_second));
                if (result_data.nibble_select !== want_beat.nibble_select)
                    report_mismatch("nibble_select", 32'(result_data.nibble_select),
                                    32'(want_beat.nibble_select));
                if (result_data.last_entry !== want_beat.last_entry)
                    report_mismatch("last_entry", 32'(result_data.last_entry),
                                    32'(want_beat.last_entry));
            end
            results_seen++;
        end

        if (hold_off)
            result_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left   = stall_left - 1;
        end
        else if (no_idle || $urandom_range(0, 99) >= 15)
            result_ready <= 1'b1;
        else
        begin
            result_ready <= 1'b0;
            stall_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
        end
    end

    // Back the block up once with a long receiver hold-off
    initial
    begin
        wait (accepted_items >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int r;
        int drain;

        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item_data    <= '0;
        result_ready <= 1'b0;
        hold_off     <= 1'b0;
        no_idle      <= 1'b0;
        stall_left     = 0;
        cycle_count    = 0;
        accepted_items = 0;
        load_beats     = 0;
        map_beats      = 0;
        double_maps    = 0;
        premix_maps    = 0;
        fixed_maps     = 0;
        results_seen   = 0;
        mismatch_count = 0;
        for (r = 0; r < 4; r++)
            key_sched[r] = 8'h00;

        // Hold reset, then release on an edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (r = 0; r < DIR_ROWS; r++)
            send_beat(directed_rows[r].beat, directed_rows[r].has_want,
                      directed_rows[r].want);

        // Random loads and maps, with one stretch free of idling
        for (r = 0; r < RANDOM_ITEMS; r++)
        begin
            no_idle <= (r >= 600 && r < 800);
            send_beat(random_item(), 1'b0, '0);
        end
        item_valid <= 1'b0;

        // Drain outstanding results, then let the block settle
        drain = 0;
        while (pending_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);
        repeat (SETTLE) @(posedge clk);

        $display("Run covered %0d key loads and %0d map beats (%0d double, %0d premix,",
                 load_beats, map_beats, double_maps, premix_maps);
        $display("%0d fixed); %0d result beats checked, %0d mismatches.",
                 fixed_maps, results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[byte_key_schedule_step.f]
src/bks_pkg.sv
src/bks_mix.sv
src/byte_key_schedule_step.sv
test/tb.sv
